### src/cobs_pkg.sv
`default_nettype none

package cobs_pkg;

   typedef logic [7:0] byte_type;

   localparam int GROUP_MAX = 61;
   localparam int ADDR_W    = $clog2(GROUP_MAX);
   localparam int LEN_W     = $clog2(GROUP_MAX + 1);

   localparam byte_type DELIM_RESET = 8'd10;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEN_W-1:0]  len_type;

   // code byte for a group of len bytes; a code equal to a nonzero delimiter becomes 0
   function automatic byte_type escaped_code(input len_type len, input byte_type delim);
      byte_type code;
      code = 8'(len) + 8'd1;
      if (delim != 8'd0 && code == delim) begin
         code = 8'd0;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

### src/cobs_req_if.sv
`default_nettype none

interface cobs_req_if;
   logic               valid;
   logic               ready;
   cobs_pkg::byte_type data_byte;
   logic               frame_last;

   modport source (output valid, output data_byte, output frame_last, input ready);
   modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

`default_nettype wire

### src/cobs_rsp_if.sv
`default_nettype none

interface cobs_rsp_if;
   logic               valid;
   logic               ready;
   cobs_pkg::byte_type out_byte;
   logic               run_last;
   logic               is_frame_end;

   modport source (output valid, output out_byte, output run_last, output is_frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input is_frame_end,
                   output ready);
endinterface

`default_nettype wire

### src/cobs_csr_if.sv
`default_nettype none

interface cobs_csr_if;
   logic               valid;
   logic               ready;
   cobs_pkg::byte_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/cobs_ram.sv
`default_nettype none

module cobs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/cobs_frame_encoder.sv
// A byte that closes a group moves the encoder to its code state, which registers the code
//   byte once the output is free; the group's data bytes then follow one per cycle while
//   the output does not stall, from the group RAM's registered read port. A byte that
//   emits nothing keeps it ready; one emitting results holds the input until all are sent.
// Reset (synchronous, active high): group empty, delimiter 10, no result pending.
//   The group RAM is not cleared; only entries written in the open group are read.
`default_nettype none

module cobs_frame_encoder (
   input wire logic    clock,
   input wire logic    reset,
   cobs_req_if.sink    req_bus,
   cobs_rsp_if.source  rsp_bus,
   cobs_csr_if.sink    csr_bus
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CODE  = 2'd1;
   localparam logic [1:0] S_DATA  = 2'd2;
   localparam logic [1:0] S_DELIM = 2'd3;

   logic [1:0]           state_ff, state_in;
   cobs_pkg::len_type    count_ff, count_in;
   cobs_pkg::len_type    len_ff, len_in;
   cobs_pkg::addr_type   idx_ff, idx_in;
   logic [1:0]           grp_ff, grp_in;
   logic                 last_ff, last_in;
   cobs_pkg::byte_type   delim_ff, delim_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   cobs_pkg::byte_type   out_byte_ff, out_byte_in;
   logic                 run_last_ff, run_last_in;
   logic                 frame_end_ff, frame_end_in;

   logic                 wr_en;
   logic                 rd_en;
   cobs_pkg::addr_type   rd_addr;
   cobs_pkg::byte_type   rd_data;

   logic                 out_free;
   logic                 accept;
   logic                 is_delim;
   logic                 full;
   logic                 emit1;
   logic                 group_done;
   logic                 data_end;
   cobs_pkg::len_type    count_plus;

   cobs_ram #(
      .WIDTH (8),
      .DEPTH (cobs_pkg::GROUP_MAX)
   ) u_group_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[cobs_pkg::ADDR_W-1:0]),
      .wr_data (req_bus.data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign count_plus = count_ff + cobs_pkg::len_type'(1);
   assign is_delim   = (req_bus.data_byte == delim_ff);
   assign full       = !is_delim && (count_plus == cobs_pkg::len_type'(cobs_pkg::GROUP_MAX));
   assign emit1      = is_delim || full;
   assign data_end   = (cobs_pkg::len_type'(idx_ff) + cobs_pkg::len_type'(1)) == len_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      grp_in       = grp_ff;
      last_in      = last_ff;
      delim_in     = delim_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      group_done   = 1'b0;

      if (csr_bus.valid) begin
         delim_in = csr_bus.data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wr_en    = !is_delim;
               len_in   = is_delim ? count_ff : count_plus;
               // groups to send: the closed one, and the final one on the frame's last byte
               grp_in   = {emit1 && req_bus.frame_last, emit1 ^ req_bus.frame_last};
               last_in  = req_bus.frame_last;
               idx_in   = '0;
               if (emit1 || req_bus.frame_last) begin
                  count_in = '0;
                  state_in = S_CODE;
               end else begin
                  count_in = count_plus;
               end
            end
         end
         S_CODE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = cobs_pkg::escaped_code(len_ff, delim_ff);
               run_last_in  = (len_ff == '0) && (grp_ff == 2'd1) && !last_ff;
               frame_end_in = 1'b0;
               if (len_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = S_DATA;
               end else begin
                  group_done = 1'b1;
               end
            end
         end
         S_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = rd_data;
               run_last_in  = data_end && (grp_ff == 2'd1) && !last_ff;
               frame_end_in = 1'b0;
               if (!data_end) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + cobs_pkg::addr_type'(1);
                  idx_in  = idx_ff + cobs_pkg::addr_type'(1);
               end else begin
                  group_done = 1'b1;
               end
            end
         end
         S_DELIM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = delim_ff;
               run_last_in  = 1'b1;
               frame_end_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase

      if (group_done) begin
         grp_in = grp_ff - 2'd1;
         priority if (grp_ff == 2'd2) begin
            // final group after a closed one is always empty
            len_in   = '0;
            state_in = S_CODE;
         end else if (last_ff) begin
            state_in = S_DELIM;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         grp_ff       <= '0;
         last_ff      <= 1'b0;
         delim_ff     <= cobs_pkg::DELIM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         grp_ff       <= grp_in;
         last_ff      <= last_in;
         delim_ff     <= delim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      out_byte_ff  <= out_byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_byte     = out_byte_ff;
   assign rsp_bus.run_last     = run_last_ff;
   assign rsp_bus.is_frame_end = frame_end_ff;

endmodule

`default_nettype wire
